// File: src/rtt_pkg.sv
package rtt_pkg;

	localparam logic [2:0] ACT_ADD    = 3'd0;
	localparam logic [2:0] ACT_ACK    = 3'd1;
	localparam logic [2:0] ACT_PAUSE  = 3'd2;
	localparam logic [2:0] ACT_RESUME = 3'd3;
	localparam logic [2:0] ACT_FAIL   = 3'd4;
	localparam logic [2:0] ACT_CLEAR  = 3'd5;
	localparam logic [2:0] ACT_TICK   = 3'd6;

	localparam logic [2:0] K_ADDED  = 3'd0;
	localparam logic [2:0] K_FULL   = 3'd1;
	localparam logic [2:0] K_ACK    = 3'd2;
	localparam logic [2:0] K_NOACK  = 3'd3;
	localparam logic [2:0] K_RESEND = 3'd4;
	localparam logic [2:0] K_GIVEUP = 3'd5;
	localparam logic [2:0] K_DONE   = 3'd6;

	localparam logic [1:0] REG_TIMEOUT = 2'd0;
	localparam logic [1:0] REG_MAXRT   = 2'd1;
	localparam logic [1:0] REG_SHIFT   = 2'd2;

	// datapath commands from the controller
	typedef struct packed {
		logic load;     // capture the input beat, clear scan state
		logic step;     // process slot at scan index
		logic finish;   // evaluate single-result actions at end of scan
	} rtt_cmd_t;

	// datapath status to the controller
	typedef struct packed {
		logic scan_end;  // current index is the last slot
		logic hit;       // current slot yields a result
	} rtt_sts_t;

endpackage

// File: src/rtt_ctrl.sv
module rtt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rtt_pkg::rtt_sts_t sts,
	input  logic            out_busy,
	output logic            out_load,
	output logic            out_last,
	output rtt_pkg::rtt_cmd_t cmd
);
	import rtt_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;

	// a scan step that makes a result waits for the output register
	always_comb begin
		cmd = '0;
		out_load = 1'b0;
		out_last = 1'b0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: cmd.load = in_valid;
			ST_SCAN: begin
				if (!(sts.hit && out_busy)) begin
					cmd.step = 1'b1;
					out_load = sts.hit;
				end
			end
			ST_FIN: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					out_load = 1'b1;
					out_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SCAN;
				ST_SCAN: if (cmd.step && sts.scan_end) state_q <= ST_FIN;
				ST_FIN:  if (cmd.finish) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: src/rtt_dp.sv
module rtt_dp #(
	parameter int TABLE_SLOTS = 16,
	parameter int OWNER_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rtt_pkg::rtt_cmd_t cmd,
	output rtt_pkg::rtt_sts_t sts,
	input  logic [2:0]        in_action,
	input  logic [3:0]        in_owner,
	input  logic [31:0]       in_msg,
	input  logic [31:0]       in_pause,
	input  logic [15:0]       in_elapsed,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_idx,
	input  logic [15:0]       cfg_data,
	output logic [2:0]        r_kind,
	output logic [3:0]        r_slot,
	output logic [3:0]        r_owner,
	output logic [31:0]       r_msg,
	output logic [7:0]        r_sends,
	output logic [15:0]       r_wake,
	output logic              r_wake_valid
);
	import rtt_pkg::*;

	localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

	logic [15:0] timeout_q;
	logic [7:0]  maxrt_q;
	logic [3:0]  shift_q;

	logic [TABLE_SLOTS-1:0] used_q;
	logic [3:0]  owner_q [TABLE_SLOTS];
	logic [31:0] msg_q   [TABLE_SLOTS];
	logic [15:0] cd_q    [TABLE_SLOTS];
	logic [7:0]  sends_q [TABLE_SLOTS];

	logic [2:0]  act_q;
	logic [3:0]  own_q;
	logic [31:0] mid_q;
	logic [15:0] padd_q;
	logic [15:0] ela_q;
	logic [IW-1:0] idx_q;
	logic        found_q;
	logic [IW-1:0] fidx_q;
	logic        any_q;
	logic [15:0] best_q;

	logic        own_ok;
	logic        u;
	logic        omatch;
	logic [15:0] cd_dec;
	logic        expire;
	logic        giveup;
	logic [15:0] cd_new;
	logic        keep;
	logic        take;
	logic [15:0] fin_cd;

	assign own_ok = ({28'd0, own_q} < 32'(OWNER_COUNT));
	assign u      = used_q[idx_q];
	assign omatch = u && own_ok && (owner_q[idx_q] == own_q);
	assign cd_dec = (cd_q[idx_q] >= ela_q) ? cd_q[idx_q] - ela_q : 16'd0;
	assign expire = u && (act_q == ACT_TICK) && (cd_dec == 16'd0);
	assign giveup = sends_q[idx_q] == maxrt_q;
	assign fin_cd = cd_q[fidx_q] + padd_q;

	// first slot that a single-slot action acts on at finish
	always_comb begin
		take = 1'b0;
		if (!found_q) begin
			case (act_q)
				ACT_ADD:   take = !u && own_ok;
				ACT_ACK:   take = omatch && (msg_q[idx_q] == mid_q);
				ACT_PAUSE, ACT_RESUME: take = omatch;
				default:   take = 1'b0;
			endcase
		end
	end

	always_comb begin
		sts.scan_end = (32'(idx_q) == TABLE_SLOTS - 1);
		sts.hit = expire || (omatch && act_q == ACT_FAIL);
		r_kind = K_DONE; r_slot = '0; r_owner = '0; r_msg = '0; r_sends = '0;
		r_wake = '0; r_wake_valid = 1'b0;
		if (cmd.step) begin
			r_slot = 4'(idx_q);
			r_owner = owner_q[idx_q];
			r_msg = msg_q[idx_q];
			r_sends = sends_q[idx_q];
			if (act_q == ACT_TICK && !giveup) begin
				r_kind = K_RESEND;
				r_sends = sends_q[idx_q] + 8'd1;
			end else begin
				r_kind = K_GIVEUP;
			end
		end else if (cmd.finish) begin
			case (act_q)
				ACT_ADD: begin
					if (found_q) begin
						r_kind = K_ADDED; r_slot = 4'(fidx_q);
						r_owner = own_q; r_msg = mid_q;
					end else r_kind = K_FULL;
				end
				ACT_ACK: begin
					if (found_q) begin
						r_kind = K_ACK; r_slot = 4'(fidx_q);
						r_owner = owner_q[fidx_q]; r_msg = msg_q[fidx_q];
						r_sends = sends_q[fidx_q];
					end else r_kind = K_NOACK;
				end
				default: r_kind = K_DONE;
			endcase
			r_wake = any_q ? best_q : 16'd0;
			r_wake_valid = any_q;
			// the finish slot was left out of the scan minimum, fold in its new value
			if (found_q) begin
				case (act_q)
					ACT_ADD: begin
						if (!any_q || timeout_q < best_q) r_wake = timeout_q;
						r_wake_valid = 1'b1;
					end
					ACT_PAUSE: begin
						if (!any_q || fin_cd < best_q) r_wake = fin_cd;
						r_wake_valid = 1'b1;
					end
					ACT_RESUME: begin
						r_wake = 16'd0;
						r_wake_valid = 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		cd_new = cd_q[idx_q];
		keep = u;
		if (act_q == ACT_TICK && u) begin
			cd_new = cd_dec;
			if (expire) begin
				if (giveup) keep = 1'b0;
				else cd_new = timeout_q;
			end
		end else if ((act_q == ACT_FAIL || act_q == ACT_CLEAR) && omatch) begin
			keep = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd4;
			maxrt_q <= 8'd4;
			shift_q <= 4'd6;
			used_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_TIMEOUT: timeout_q <= cfg_data;
					REG_MAXRT:   maxrt_q <= cfg_data[7:0];
					REG_SHIFT:   shift_q <= cfg_data[3:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				idx_q <= '0;
				found_q <= 1'b0;
				any_q <= 1'b0;
			end
			if (cmd.step) begin
				if (!sts.scan_end) idx_q <= idx_q + IW'(1);
				used_q[idx_q] <= keep;
				if (act_q == ACT_TICK && u) begin
					cd_q[idx_q] <= cd_new;
					if (expire && !giveup) sends_q[idx_q] <= sends_q[idx_q] + 8'd1;
				end
				if (keep && !take && (!any_q || cd_new < best_q)) begin
					best_q <= cd_new;
					any_q <= 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
					fidx_q <= idx_q;
				end
			end
			if (cmd.finish && found_q) begin
				case (act_q)
					ACT_ADD: begin
						used_q[fidx_q] <= 1'b1;
						owner_q[fidx_q] <= own_q;
						msg_q[fidx_q] <= mid_q;
						sends_q[fidx_q] <= 8'd0;
						cd_q[fidx_q] <= timeout_q;
					end
					ACT_ACK: used_q[fidx_q] <= 1'b0;
					ACT_PAUSE: cd_q[fidx_q] <= fin_cd;
					ACT_RESUME: cd_q[fidx_q] <= 16'd0;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= in_action;
			own_q <= in_owner;
			mid_q <= in_msg;
			padd_q <= 16'(in_pause >> shift_q);
			ela_q <= in_elapsed;
		end
	end
endmodule

// File: src/retransmit_timer_table.sv
// an item scans all TABLE_SLOTS slots, one per cycle unless a result waits for
// the output register, then gives its final result
// a new item is taken only after the slot-serial scan and final result of the last one
// results wait in one output register; a result stalls while it is full and not being drained
// reset: arst_n clears the table, the controller and the registers to 4, 4, 6
module retransmit_timer_table #(
	parameter int TABLE_SLOTS = 16,
	parameter int OWNER_COUNT = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// action[2:0], owner_id[6:3], message_id[38:7], pause_ms[70:39], elapsed_ticks[86:71]
	input  logic [87:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// kind[2:0], slot[6:3], owner_out[10:7], message_out[42:11], send_count[50:43],
	// next_wake[66:51], wake_valid[67]
	output logic [71:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rtt_pkg::*;

	rtt_cmd_t cmd;
	rtt_sts_t sts;
	logic out_load, out_last;

	// result fields from the datapath
	logic [2:0]  r_kind;
	logic [3:0]  r_slot, r_owner;
	logic [31:0] r_msg;
	logic [7:0]  r_sends;
	logic [15:0] r_wake;
	logic        r_wake_valid;

	// output register
	logic        ovalid_q;
	logic [71:0] odata_q;
	logic        olast_q;
	logic        out_busy;

	assign cfg_ready = 1'b1;
	assign out_busy = ovalid_q && !m_axis_tready;

	rtt_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.sts(sts), .out_busy(out_busy),
		.out_load(out_load), .out_last(out_last), .cmd(cmd)
	);

	rtt_dp #(.TABLE_SLOTS(TABLE_SLOTS), .OWNER_COUNT(OWNER_COUNT)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.in_action(s_axis_tdata[2:0]), .in_owner(s_axis_tdata[6:3]),
		.in_msg(s_axis_tdata[38:7]), .in_pause(s_axis_tdata[70:39]),
		.in_elapsed(s_axis_tdata[86:71]),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.r_kind(r_kind), .r_slot(r_slot), .r_owner(r_owner), .r_msg(r_msg),
		.r_sends(r_sends), .r_wake(r_wake), .r_wake_valid(r_wake_valid)
	);

	// output register: loads whenever it is empty or being drained
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (out_load) begin
			ovalid_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			odata_q <= {4'd0, r_wake_valid, r_wake, r_sends, r_msg, r_owner, r_slot, r_kind};
			olast_q <= out_last;
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tlast  = olast_q;
endmodule

// File: src/rtt_chk.sv
module rtt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [71:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	// a result beat held under backpressure keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// no new item is taken while a result other than the last of an item is held
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
		else $error("input ready mid item");

	// only the last result carries the wake report
	a_wake: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[67:51] == 17'd0)
		else $error("wake on non-last result");

	// next_wake is zero whenever wake_valid is low (empty table or non-last result)
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[67] |-> m_axis_tdata[66:51] == 16'd0)
		else $error("wake without occupied slot");
endmodule

bind retransmit_timer_table rtt_chk u_rtt_chk (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);

// File: tb/sv/retransmit_timer_table_test.sv
`timescale 1ns / 1ps

module retransmit_timer_table_test;
	import rtt_pkg::*;

	localparam int SLOTS = 16;
	localparam int OWNERS = 16;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [15:0] elapsed;
		logic [31:0] pause_ms;
		logic [31:0] msg;
		logic [3:0]  owner;
		logic [2:0]  action;
	} table_op_t;

	typedef struct packed {
		logic        last;
		logic        wake_valid;
		logic [15:0] next_wake;
		logic [7:0]  sends;
		logic [31:0] msg;
		logic [3:0]  owner;
		logic [3:0]  slot;
		logic [2:0]  kind;
	} table_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [87:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [71:0] m_axis_tdata;
	logic m_axis_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	always #10 clk = ~clk;

	retransmit_timer_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the table and its registers
	logic [15:0] timeout_ticks;
	logic [7:0]  max_sends;
	logic [3:0]  shift;
	logic        used [SLOTS];
	logic [3:0]  owner_of [SLOTS];
	logic [31:0] msg_of [SLOTS];
	logic [15:0] count_of [SLOTS];
	logic [7:0]  sends_of [SLOTS];

	table_op_t    pending_ops[$];
	table_event_t expected_events[$];

	int errors = 0;
	int reported = 0;
	int events_seen = 0;
	int ops_sent = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_off_req = 1'b0;
	bit stim_done = 1'b0;
	int owner_base = 0;

	function automatic table_event_t slot_event(logic [2:0] kind, int s);
		table_event_t e;
		e = '0;
		e.kind = kind;
		e.slot = s[3:0];
		e.owner = owner_of[s];
		e.msg = msg_of[s];
		e.sends = sends_of[s];
		return e;
	endfunction

	function automatic table_event_t bare_event(logic [2:0] kind);
		table_event_t e;
		e = '0;
		e.kind = kind;
		return e;
	endfunction

	// apply one beat to the shadow table and queue what it must produce
	task automatic predict_op(table_op_t op);
		table_event_t ev[$];
		table_event_t e;
		int s;
		bit found;
		logic [15:0] best;
		s = -1;
		case (op.action)
			ACT_ADD: begin
				if (op.owner < OWNERS)
					for (int i = 0; i < SLOTS; i++)
						if (!used[i] && s < 0) s = i;
				if (s < 0) ev.push_back(bare_event(K_FULL));
				else begin
					used[s] = 1'b1;
					owner_of[s] = op.owner;
					msg_of[s] = op.msg;
					sends_of[s] = '0;
					count_of[s] = timeout_ticks;
					ev.push_back(slot_event(K_ADDED, s));
				end
			end
			ACT_ACK: begin
				if (op.owner < OWNERS)
					for (int i = 0; i < SLOTS; i++)
						if (s < 0 && used[i] && owner_of[i] == op.owner && msg_of[i] == op.msg)
							s = i;
				if (s < 0) ev.push_back(bare_event(K_NOACK));
				else begin
					used[s] = 1'b0;
					ev.push_back(slot_event(K_ACK, s));
				end
			end
			ACT_PAUSE, ACT_RESUME: begin
				if (op.owner < OWNERS)
					for (int i = 0; i < SLOTS; i++)
						if (s < 0 && used[i] && owner_of[i] == op.owner) s = i;
				if (s >= 0) begin
					if (op.action == ACT_PAUSE)
						count_of[s] = count_of[s] + 16'(op.pause_ms >> shift);
					else
						count_of[s] = '0;
				end
				ev.push_back(bare_event(K_DONE));
			end
			ACT_FAIL, ACT_CLEAR: begin
				if (op.owner < OWNERS)
					for (int i = 0; i < SLOTS; i++)
						if (used[i] && owner_of[i] == op.owner) begin
							used[i] = 1'b0;
							if (op.action == ACT_FAIL) ev.push_back(slot_event(K_GIVEUP, i));
						end
				ev.push_back(bare_event(K_DONE));
			end
			ACT_TICK: begin
				for (int i = 0; i < SLOTS; i++)
					if (used[i])
						count_of[i] = (count_of[i] >= op.elapsed) ? count_of[i] - op.elapsed : '0;
				for (int i = 0; i < SLOTS; i++)
					if (used[i] && count_of[i] == 0) begin
						if (sends_of[i] == max_sends) begin
							used[i] = 1'b0;
							ev.push_back(slot_event(K_GIVEUP, i));
						end else begin
							sends_of[i] = sends_of[i] + 8'd1;
							count_of[i] = timeout_ticks;
							ev.push_back(slot_event(K_RESEND, i));
						end
					end
				ev.push_back(bare_event(K_DONE));
			end
			default: ev.push_back(bare_event(K_DONE));
		endcase
		found = 1'b0;
		best = '0;
		for (int i = 0; i < SLOTS; i++)
			if (used[i] && (!found || count_of[i] < best)) begin
				best = count_of[i];
				found = 1'b1;
			end
		e = ev.pop_back();
		e.next_wake = best;
		e.wake_valid = found;
		e.last = 1'b1;
		ev.push_back(e);
		foreach (ev[j]) expected_events.push_back(ev[j]);
	endtask

	// driver: one beat per handshake, random gaps unless no_idle is set
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_op(table_op_t'(s_axis_tdata[86:0]));
				ops_sent++;
			end
			if ((s_axis_tvalid && !s_axis_tready) ||
			    (pending_ops.size() > 0 && (no_idle || $urandom_range(99) >= 9))) begin
				if (!(s_axis_tvalid && !s_axis_tready)) begin
					s_axis_tdata <= {1'b0, pending_ops.pop_front()};
					s_axis_tvalid <= 1'b1;
				end
			end else
				s_axis_tvalid <= 1'b0;
		end
	end

	// monitor: ready idles at random, or is held low for a long stretch on request
	always @(posedge clk) begin
		table_event_t got, want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = table_event_t'({m_axis_tlast, m_axis_tdata[67:0]});
				events_seen++;
				if (expected_events.size() == 0) begin
					errors++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result beat %h", got);
					end
				end else begin
					want = expected_events.pop_front();
					if (got !== want) begin
						errors++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: kind %0d/%0d slot %0d/%0d owner %0d/%0d msg %h/%h",
								got.kind, want.kind, got.slot, want.slot, got.owner, want.owner,
								got.msg, want.msg);
							$display("  sends %0d/%0d wake %0d/%0d valid %0b/%0b last %0b/%0b",
								got.sends, want.sends, got.next_wake, want.next_wake,
								got.wake_valid, want.wake_valid, got.last, want.last);
						end
					end
				end
			end
			m_axis_tready <= !hold_off_req && (no_idle || $urandom_range(99) >= 9);
		end
	end

	// watchdog on cycles with no accepted beat of any kind
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
		    (cfg_valid && cfg_ready) || stim_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", expected_events.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic push_op(logic [2:0] action, logic [3:0] owner, logic [31:0] msg,
			logic [31:0] pause_ms, logic [15:0] elapsed);
		table_op_t op;
		op.action = action;
		op.owner = owner;
		op.msg = msg;
		op.pause_ms = pause_ms;
		op.elapsed = elapsed;
		pending_ops.push_back(op);
	endtask

	// queue drained, table quiet, then the scan has had time to finish
	task automatic wait_drained();
		while (pending_ops.size() > 0 || s_axis_tvalid || expected_events.size() > 0)
			@(posedge clk);
		repeat (SLOTS + 8) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_TIMEOUT: timeout_ticks = value;
			REG_MAXRT:   max_sends = value[7:0];
			REG_SHIFT:   shift = value[3:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] t, logic [7:0] m, logic [3:0] sh);
		wait_drained();
		write_reg(REG_TIMEOUT, t);
		write_reg(REG_MAXRT, {8'd0, m});
		write_reg(REG_SHIFT, {12'd0, sh});
	endtask

	// mostly live traffic on a few owners, so acks hit and timers expire
	task automatic random_ops(int n);
		logic [2:0] a;
		logic [3:0] o;
		int s;
		for (int k = 0; k < n; k++) begin
			o = 4'(owner_base + $urandom_range(3));
			a = 3'($urandom_range(7));
			if ($urandom_range(9) < 3) a = ACT_ADD;
			else if ($urandom_range(9) < 2) a = ACT_TICK;
			s = $urandom_range(SLOTS - 1);
			if (a == ACT_ACK && used[s] && $urandom_range(3) != 0)
				push_op(a, owner_of[s], msg_of[s], $urandom, 16'($urandom));
			else
				push_op(a, ($urandom_range(9) == 0) ? 4'($urandom) : o, $urandom, $urandom,
					($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(6)));
			// keep prediction in step with the queue for ack targets
			if (pending_ops.size() > 4) wait_drained();
		end
	endtask

	initial begin
		timeout_ticks = 16'd4;
		max_sends = 8'd4;
		shift = 4'd6;
		for (int i = 0; i < SLOTS; i++) begin
			used[i] = 1'b0;
			owner_of[i] = '0;
			msg_of[i] = '0;
			count_of[i] = '0;
			sends_of[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, every action, full table, wrap cases
		no_idle = 1'b1;
		push_op(ACT_TICK, 4'd0, '0, '0, 16'd0);
		push_op(ACT_ADD, 4'd15, 32'hFFFF_FFFF, '0, '0);
		push_op(ACT_ADD, 4'd0, 32'h0, '0, '0);
		push_op(ACT_ACK, 4'd15, 32'hFFFF_FFFF, '0, '0);
		push_op(ACT_ACK, 4'd0, 32'h1, '0, '0);
		push_op(ACT_PAUSE, 4'd0, '0, 32'hFFFF_FFFF, '0);
		push_op(ACT_PAUSE, 4'd9, '0, 32'h40, '0);
		push_op(ACT_RESUME, 4'd0, '0, '0, '0);
		push_op(ACT_TICK, 4'd0, '0, '0, 16'hFFFF);
		push_op(3'd7, 4'd5, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 16'h5555);
		for (int i = 0; i < SLOTS + 1; i++) push_op(ACT_ADD, 4'(i), 32'(i * 7), '0, '0);
		push_op(ACT_FAIL, 4'd3, '0, '0, '0);
		push_op(ACT_CLEAR, 4'd4, '0, '0, '0);
		push_op(ACT_TICK, 4'd0, '0, '0, 16'd4);
		push_op(ACT_FAIL, 4'd5, '0, '0, '0);
		wait_drained();
		no_idle = 1'b0;

		// zero timeout and give-up at zero retries; shift extreme
		set_regs(16'd0, 8'd0, 4'd0);
		push_op(ACT_PAUSE, 4'd1, '0, 32'h0001_FFFF, '0);
		push_op(ACT_TICK, 4'd0, '0, '0, 16'd0);
		random_ops(20);

		// long timeout with the largest send limit and shift
		set_regs(16'hFFFF, 8'd255, 4'd15);
		owner_base = 8;
		random_ops(30);
		set_regs(16'd1, 8'd2, 4'd3);
		for (int i = 0; i < 6; i++) push_op(ACT_TICK, 4'd0, '0, '0, 16'd1);
		owner_base = 0;
		random_ops(30);

		// receiver holds off while the sender keeps offering
		hold_off_req = 1'b1;
		for (int i = 0; i < 12; i++) push_op(ACT_TICK, 4'd0, '0, '0, 16'd1);
		repeat (400) @(posedge clk);
		hold_off_req = 1'b0;
		wait_drained();

		set_regs(16'd3, 8'd1, 4'd6);
		no_idle = 1'b1;
		owner_base = 12;
		random_ops(20);
		no_idle = 1'b0;
		set_regs(16'd4, 8'd4, 4'd6);
		random_ops(10);

		wait_drained();
		stim_done = 1'b1;
		$display("%0d input beats and %0d result beats checked over six register settings",
			ops_sent, events_seen);
		if (errors == 0)
			$display("Testbench completed without errors");
		else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
